// ----- hdl/kept_pkg.sv -----
// Shared types and constants of the kick envelope and pitch tracker.
`timescale 1ns / 1ps

package kept_pkg;

  // Fixed field widths.
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned HZ_W       = 16;
  localparam int unsigned QUO_W      = RATE_W + 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned SMOOTH_W   = 12;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd2;

  // Register reset values.
  localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd64187;
  localparam logic [COEF_W-1:0] RELEASE_RST = 16'd65522;
  localparam logic [RATE_W-1:0] RATE_RST    = 18'd48000;

  // Pitch tracking constants.
  localparam logic [CNT_W-1:0]    MIN_COUNT  = 16'd4;
  localparam logic [CNT_W-1:0]    COUNT_MAX  = 16'hFFFF;
  localparam logic [QUO_W-1:0]    HZ_LOW_Q8  = 26'd6400;
  localparam logic [QUO_W-1:0]    HZ_HIGH_Q8 = 26'd40960;
  localparam logic [SMOOTH_W-1:0] SMOOTH_Q16 = 12'd3277;
  localparam logic [15:0]         ROUND_HALF = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_DIV,
    ST_PITCH_MUL,
    ST_PITCH_UPD,
    ST_OUT
  } kept_state_e;

  typedef struct packed {
    logic load_sample;
    logic env_mul;
    logic env_upd;
    logic div_start;
    logic pitch_mul;
    logic pitch_upd;
    logic out_load;
  } kept_cmd_t;

  typedef struct packed {
    logic crossing;
    logic div_done;
    logic out_free;
  } kept_sts_t;

endpackage

// ----- hdl/kept_div.sv -----
// Restoring divider, one quotient bit per cycle, for the crossing frequency.
`timescale 1ns / 1ps

module kept_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [kept_pkg::QUO_W-1:0] dividend_i,
  input  logic [kept_pkg::CNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [kept_pkg::QUO_W-1:0] quotient_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic [kept_pkg::QUO_W-1:0] dvd_q, dvd_d;
  logic [kept_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [kept_pkg::CNT_W-1:0] dsr_q, dsr_d;
  logic [kept_pkg::CNT_W:0]   trial;
  logic [kept_pkg::CNT_W:0]   trial_sub;
  logic                       fits;

  assign trial     = {rem_q, dvd_q[kept_pkg::QUO_W-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign fits      = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(kept_pkg::QUO_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // The dividend shifts out at the top while quotient bits enter at the bottom.
      dvd_d = {dvd_q[kept_pkg::QUO_W-2:0], fits};
      rem_d = fits ? trial_sub[kept_pkg::CNT_W-1:0] : trial[kept_pkg::CNT_W-1:0];
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- hdl/kept_dp.sv -----
// Datapath: configuration registers, envelope, crossing counter, pitch smoothing, output register.
`timescale 1ns / 1ps

module kept_dp #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kept_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kept_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [SAMPLE_BITS-1:0]          key_sample_i,
  input  kept_pkg::kept_cmd_t             cmd_i,
  output kept_pkg::kept_sts_t             sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [15:0]                     envelope_o,
  output logic [kept_pkg::HZ_W-1:0]       pitch_hz_o,
  output logic                            pitch_updated_o
);

  localparam int unsigned SB       = SAMPLE_BITS;
  localparam int unsigned PROD_W   = SB + kept_pkg::COEF_W;
  localparam int unsigned EXT_W    = (SB > 16) ? SB : 16;
  localparam int unsigned MAG_GATE = (2 ** (SB - 1)) / 100;
  localparam int unsigned PPROD_W  = kept_pkg::SMOOTH_W + kept_pkg::HZ_W;

  // Configuration registers.
  logic [kept_pkg::COEF_W-1:0] attack_q, release_q;
  logic [kept_pkg::RATE_W-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= kept_pkg::ATTACK_RST;
      release_q <= kept_pkg::RELEASE_RST;
      rate_q    <= kept_pkg::RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kept_pkg::CFG_ATTACK:  attack_q  <= cfg_wdata_i[kept_pkg::COEF_W-1:0];
        kept_pkg::CFG_RELEASE: release_q <= cfg_wdata_i[kept_pkg::COEF_W-1:0];
        kept_pkg::CFG_RATE:    rate_q    <= cfg_wdata_i[kept_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample and magnitude.
  logic [SB-1:0] key_q;
  logic [SB:0]   key_neg;
  logic [SB-1:0] mag;

  assign key_neg = (SB+1)'(0) - {key_q[SB-1], key_q};
  assign mag     = key_q[SB-1] ? key_neg[SB-1:0] : key_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      key_q <= key_sample_i;
    end
  end

  // Envelope blend: product registered, then rounded and applied.
  logic [SB-1:0]     env_q, env_d;
  logic [SB:0]       ediff, ediff_rev;
  logic              eneg;
  logic [SB-1:0]     eabs;
  logic [kept_pkg::COEF_W-1:0] coef;
  logic [PROD_W-1:0] eprod_q;
  logic              eneg_q;
  logic [PROD_W:0]   eround;
  logic [SB-1:0]     epart;

  assign ediff     = {1'b0, env_q} - {1'b0, mag};
  assign ediff_rev = {1'b0, mag} - {1'b0, env_q};
  assign eneg      = ediff[SB];
  assign eabs      = eneg ? ediff_rev[SB-1:0] : ediff[SB-1:0];
  assign coef      = eneg ? attack_q : release_q;
  assign eround    = (PROD_W+1)'(eprod_q) + (PROD_W+1)'(kept_pkg::ROUND_HALF);
  assign epart     = eround[SB+15:16];
  assign env_d     = eneg_q ? (mag - epart) : (mag + epart);

  always_ff @(posedge clk_i) begin
    if (cmd_i.env_mul) begin
      eprod_q <= PROD_W'(coef) * PROD_W'(eabs);
      eneg_q  <= eneg;
    end
  end

  // Crossing detection and saturating sample counter.
  logic [SB-1:0]              prev_key_q;
  logic [kept_pkg::CNT_W-1:0] cnt_q, cnt_inc;
  logic                       prev_nonpos, key_pos, crossing;

  assign cnt_inc     = (cnt_q == kept_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign prev_nonpos = prev_key_q[SB-1] || (prev_key_q == '0);
  assign key_pos     = !key_q[SB-1] && (key_q != '0);
  assign crossing    = prev_nonpos && key_pos && (cnt_inc > kept_pkg::MIN_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q      <= '0;
      prev_key_q <= '0;
      cnt_q      <= '0;
    end else if (cmd_i.env_upd) begin
      env_q      <= env_d;
      prev_key_q <= key_q;
      cnt_q      <= crossing ? '0 : cnt_inc;
    end
  end

  // Frequency from the crossing interval.
  logic [kept_pkg::QUO_W-1:0] quo;
  logic                       div_done;

  kept_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({rate_q, 8'h00}),
    .divisor_i  (cnt_inc),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Pitch smoothing.
  logic [kept_pkg::HZ_W-1:0] est_q, est_d;
  logic [kept_pkg::HZ_W:0]   pdiff, pdiff_rev;
  logic                      pneg, pneg_q;
  logic [kept_pkg::HZ_W-1:0] pabs;
  logic [PPROD_W-1:0]        pprod_q;
  logic [PPROD_W:0]          pround;
  logic [kept_pkg::HZ_W-1:0] ppart;
  logic                      accept_hz, ok_q;
  logic                      upd_q;

  assign pdiff     = {1'b0, quo[kept_pkg::HZ_W-1:0]} - {1'b0, est_q};
  assign pdiff_rev = {1'b0, est_q} - {1'b0, quo[kept_pkg::HZ_W-1:0]};
  assign pneg      = pdiff[kept_pkg::HZ_W];
  assign pabs      = pneg ? pdiff_rev[kept_pkg::HZ_W-1:0] : pdiff[kept_pkg::HZ_W-1:0];
  assign accept_hz = (quo > kept_pkg::HZ_LOW_Q8) && (quo < kept_pkg::HZ_HIGH_Q8)
                     && (mag > SB'(MAG_GATE));
  assign pround    = (PPROD_W+1)'(pprod_q) + (PPROD_W+1)'(kept_pkg::ROUND_HALF);
  assign ppart     = kept_pkg::HZ_W'(pround[PPROD_W:16]);
  assign est_d     = pneg_q ? (est_q - ppart) : (est_q + ppart);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pitch_mul) begin
      pprod_q <= PPROD_W'(kept_pkg::SMOOTH_Q16) * PPROD_W'(pabs);
      pneg_q  <= pneg;
      ok_q    <= accept_hz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      upd_q <= 1'b0;
    end else if (cmd_i.load_sample) begin
      upd_q <= 1'b0;
    end else if (cmd_i.pitch_upd && ok_q) begin
      est_q <= est_d;
      upd_q <= 1'b1;
    end
  end

  // Output register; the next request may be taken while this one waits.
  logic [EXT_W-1:0] env_ext;
  logic             oval_q;
  logic [15:0]      oenv_q;
  logic [kept_pkg::HZ_W-1:0] opitch_q;
  logic             oupd_q;

  assign env_ext = EXT_W'(env_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      oenv_q   <= env_ext[15:0];
      opitch_q <= est_q;
      oupd_q   <= upd_q;
    end
  end

  assign sts_o.crossing = crossing;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !oval_q || out_ready_i;

  assign out_valid_o     = oval_q;
  assign envelope_o      = oenv_q;
  assign pitch_hz_o      = opitch_q;
  assign pitch_updated_o = oupd_q;

endmodule

// ----- hdl/kept_ctrl.sv -----
// Controller: sequences the envelope, divider, smoothing and output steps of one request.
`timescale 1ns / 1ps

module kept_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kept_pkg::kept_sts_t sts_i,
  output kept_pkg::kept_cmd_t cmd_o
);

  kept_pkg::kept_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kept_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kept_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = kept_pkg::ST_ENV_MUL;
      end
      kept_pkg::ST_ENV_MUL:   state_d = kept_pkg::ST_ENV_UPD;
      kept_pkg::ST_ENV_UPD: begin
        state_d = sts_i.crossing ? kept_pkg::ST_DIV : kept_pkg::ST_OUT;
      end
      kept_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = kept_pkg::ST_PITCH_MUL;
      end
      kept_pkg::ST_PITCH_MUL: state_d = kept_pkg::ST_PITCH_UPD;
      kept_pkg::ST_PITCH_UPD: state_d = kept_pkg::ST_OUT;
      kept_pkg::ST_OUT: begin
        if (sts_i.out_free) state_d = kept_pkg::ST_IDLE;
      end
      default:                state_d = kept_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      kept_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.load_sample = in_valid_i;
      end
      kept_pkg::ST_ENV_MUL:   cmd_o.env_mul = 1'b1;
      kept_pkg::ST_ENV_UPD: begin
        // The divider latches the incremented count in the same cycle.
        cmd_o.env_upd   = 1'b1;
        cmd_o.div_start = sts_i.crossing;
      end
      kept_pkg::ST_DIV:       ;
      kept_pkg::ST_PITCH_MUL: cmd_o.pitch_mul = 1'b1;
      kept_pkg::ST_PITCH_UPD: cmd_o.pitch_upd = 1'b1;
      kept_pkg::ST_OUT:       cmd_o.out_load = sts_i.out_free;
      default:                ;
    endcase
  end

endmodule

// ----- hdl/kick_envelope_pitch_tracker.sv -----
// Each request runs the envelope steps; one with an upward zero crossing also waits for
// the restoring divider that forms the crossing frequency, then runs the pitch smoothing.
// A result is loaded into the output register once that register is free or being read.
// The output register holds a result while the next request is taken.
// Reset clears envelope, previous sample, counter and pitch estimate, and
// loads the configuration registers with their default values.
`timescale 1ns / 1ps

module kick_envelope_pitch_tracker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kept_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kept_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   key_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [15:0]                     envelope_o,
  output logic [kept_pkg::HZ_W-1:0]       pitch_hz_o,
  output logic                            pitch_updated_o
);

  kept_pkg::kept_cmd_t cmd;
  kept_pkg::kept_sts_t sts;

  kept_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kept_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .key_sample_i    (key_sample_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .envelope_o      (envelope_o),
    .pitch_hz_o      (pitch_hz_o),
    .pitch_updated_o (pitch_updated_o)
  );

endmodule

// ----- tb/tb_kick_envelope_pitch_tracker.sv -----
// Self-checking testbench for the kick envelope follower and pitch tracker.
`timescale 1ns / 1ps

module tb_kick_envelope_pitch_tracker;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SHOWN_ERRORS  = 10;
  localparam int          MAG_GATE      = (1 << 15) / 100;
  localparam int          PHASE_ITEMS   = 170;

  typedef struct packed {
    logic [15:0] envelope;
    logic [15:0] pitch_hz;
    logic        pitch_updated;
  } tracker_out_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [kept_pkg::CFG_IDX_W-1:0]  cfg_idx    = kept_pkg::CFG_ATTACK;
  logic [kept_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_ready;
  logic signed [15:0]              key_sample = '0;
  logic                            out_valid;
  logic                            out_ready  = 1'b0;
  logic [15:0]                     envelope;
  logic [kept_pkg::HZ_W-1:0]       pitch_hz;
  logic                            pitch_updated;

  // Predictor state and its copy of the configuration.
  int          env_q15        = 0;
  int          last_key       = 0;
  int          crossing_count = 0;
  int          pitch_q8       = 0;
  int unsigned attack_q16     = kept_pkg::ATTACK_RST;
  int unsigned release_q16    = kept_pkg::RELEASE_RST;
  int unsigned rate_hz        = kept_pkg::RATE_RST;

  tracker_out_t predicted_readings[$];

  int unsigned cycles         = 0;
  int unsigned failures       = 0;
  int unsigned samples_taken  = 0;
  int unsigned results_seen   = 0;
  int unsigned updates_seen   = 0;
  int unsigned reg_writes     = 0;
  bit          gaps_off       = 1'b0;
  bit          hold_request   = 1'b0;

  kick_envelope_pitch_tracker dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .key_sample_i   (key_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .envelope_o     (envelope),
    .pitch_hz_o     (pitch_hz),
    .pitch_updated_o(pitch_updated)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               predicted_readings.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // base + round(coef * diff / 2^16), with the rounding taken half away from zero.
  function automatic int blend_q16(input int base, input int diff, input int unsigned coef);
    longint unsigned mag;
    longint unsigned part;
    mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
    part = (longint'(coef) * mag + 64'h8000) >> 16;
    return (diff < 0) ? base - int'(part) : base + int'(part);
  endfunction

  task automatic predict_step(input logic signed [15:0] sample);
    int           key;
    int           mag;
    int unsigned  coef;
    longint       hz;
    tracker_out_t want;
    key  = sample;
    mag  = (key < 0) ? -key : key;
    coef = (mag > env_q15) ? attack_q16 : release_q16;
    env_q15 = blend_q16(mag, env_q15 - mag, coef);
    if (crossing_count < kept_pkg::COUNT_MAX) crossing_count++;
    want.pitch_updated = 1'b0;
    if (last_key <= 0 && key > 0 && crossing_count > kept_pkg::MIN_COUNT) begin
      hz = (longint'(rate_hz) << 8) / crossing_count;
      if (hz > kept_pkg::HZ_LOW_Q8 && hz < kept_pkg::HZ_HIGH_Q8 && mag > MAG_GATE) begin
        pitch_q8 = blend_q16(pitch_q8, int'(hz) - pitch_q8, kept_pkg::SMOOTH_Q16);
        want.pitch_updated = 1'b1;
      end
      // A crossing past the minimum count restarts the period even when rejected.
      crossing_count = 0;
    end
    last_key      = key;
    want.envelope = env_q15[15:0];
    want.pitch_hz = pitch_q8[15:0];
    predicted_readings.push_back(want);
  endtask

  always @(posedge clk) begin : scoreboard
    tracker_out_t want;
    tracker_out_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_step(key_sample);
        samples_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        got.envelope      = envelope;
        got.pitch_hz      = pitch_hz;
        got.pitch_updated = pitch_updated;
        if (got.pitch_updated === 1'b1) updates_seen++;
        if (predicted_readings.size() == 0) begin
          failures++;
          if (failures <= SHOWN_ERRORS)
            $display("result %0d arrived with no request pending", results_seen);
        end else begin
          want = predicted_readings.pop_front();
          if (got.envelope !== want.envelope || got.pitch_hz !== want.pitch_hz ||
              got.pitch_updated !== want.pitch_updated) begin
            failures++;
            if (failures <= SHOWN_ERRORS)
              $display({"result %0d: envelope exp %0d got %0d, pitch_hz exp %0d got %0d,",
                        " updated exp %0b got %0b"},
                       results_seen, want.envelope, got.envelope, want.pitch_hz,
                       got.pitch_hz, want.pitch_updated, got.pitch_updated);
          end
        end
      end
    end
  end

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (gaps_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  initial begin : receiver
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Valid is left high on return so that a following request can go back to back.
  task automatic send_key(input int value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    key_sample <= value[15:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_cycle(input int neg_len, input int pos_len, input int amp);
    int i;
    for (i = 0; i < neg_len; i++) send_key(-amp);
    for (i = 0; i < pos_len; i++) send_key(amp);
  endtask

  // The first edge lets the scoreboard record the request taken at the last one.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kept_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data[kept_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
    case (idx)
      kept_pkg::CFG_ATTACK:  attack_q16  = data & 32'hFFFF;
      kept_pkg::CFG_RELEASE: release_q16 = data & 32'hFFFF;
      kept_pkg::CFG_RATE:    rate_hz     = data & 32'h3FFFF;
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned attack, input int unsigned release_c,
                            input int unsigned rate);
    drain_block();
    write_reg(kept_pkg::CFG_ATTACK, attack);
    write_reg(kept_pkg::CFG_RELEASE, release_c);
    write_reg(kept_pkg::CFG_RATE, rate);
  endtask

  function automatic int pick_amplitude();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(400, 30000);
    if (r < 85) return $urandom_range(0, 400);
    return 32767;
  endfunction

  // Field extremes under the reset configuration, the most negative sample among them.
  task automatic test_extremes();
    send_key(0);
    send_key(32767);
    send_key(-32768);
    send_key(-32768);
    send_key(-1);
    send_key(1);
  endtask

  task automatic test_pitch_rules();
    set_config(kept_pkg::ATTACK_RST, kept_pkg::RELEASE_RST, 500);
    send_cycle(3, 2, 5000);
    send_cycle(3, 2, 5000);
    // A crossing too soon after the last must neither update nor restart the count.
    send_cycle(1, 1, 5000);
    send_cycle(2, 2, 5000);
    // The magnitude gate is strict: 327 is rejected, 328 passes.
    send_cycle(3, 2, MAG_GATE);
    send_cycle(3, 2, MAG_GATE + 1);
    // At 800 Hz a five-sample period lands exactly on the upper band edge.
    set_config(kept_pkg::ATTACK_RST, kept_pkg::RELEASE_RST, 800);
    send_cycle(3, 2, 6000);
  endtask

  task automatic test_output_hold();
    int i;
    drain_block();
    gaps_off     = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 24; i++) send_key((i % 6 < 3) ? -8000 : 8000);
    gaps_off = 1'b0;
  endtask

  task automatic run_random_phase(input int n);
    int sent;
    int half;
    int amp;
    int i;
    int v;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 2) begin
        half = $urandom_range(1, 8);
        for (i = 0; i < half; i++) send_key($urandom_range(0, 65535));
        sent += half;
      end else begin
        half = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
        amp  = pick_amplitude();
        for (i = 0; i < half; i++) begin
          v = -(amp - $urandom_range(0, amp / 4));
          if (amp == 32767 && $urandom_range(0, 1) == 1) v = -32768;
          send_key(v);
        end
        sent += half;
        if ($urandom_range(0, 3) == 0) begin
          send_key(0);
          sent++;
        end
        half = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
        for (i = 0; i < half; i++) send_key(amp - $urandom_range(0, amp / 4));
        sent += half;
      end
    end
  endtask

  task automatic test_random_phases();
    int p;
    for (p = 0; p < 7; p++) begin
      case (p)
        0: set_config(0, 65535, 2000);
        1: set_config(65535, 0, 1000);
        2: set_config($urandom_range(0, 65535), $urandom_range(0, 65535), 0);
        3: set_config($urandom_range(0, 65535), $urandom_range(0, 65535), 262143);
        4: set_config($urandom_range(60000, 65535), $urandom_range(60000, 65535),
                      $urandom_range(8000, 192000));
        default: set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(500, 4000));
      endcase
      // One phase runs with both sides flat out.
      gaps_off = (p == 5);
      run_random_phase(PHASE_ITEMS);
      gaps_off = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_pitch_rules();
    test_output_hold();
    test_random_phases();
    drain_block();
    $display("covered %0d samples and %0d results, %0d of them pitch updates,",
             samples_taken, results_seen, updates_seen);
    $display("over %0d register writes, the gate and band edges and a long output stall",
             reg_writes);
    if (failures == 0 && predicted_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", failures, predicted_readings.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- kick_envelope_pitch_tracker.f -----
hdl/kept_pkg.sv
hdl/kept_div.sv
hdl/kept_dp.sv
hdl/kept_ctrl.sv
hdl/kick_envelope_pitch_tracker.sv
tb/tb_kick_envelope_pitch_tracker.sv
